>>> design/srfifo_pkg.sv
package srfifo_pkg;

    // Storage geometry. The depth is a power of two, so the pointers wrap by themselves.
    localparam int DEPTH    = 1024;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int SAMPLE_W = 32;
    localparam int MAX_POP  = 64;
    localparam int COUNT_W  = 7;
    localparam int OCC_W    = 10;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_PUSHED  = 2'd0,
        STAT_DROPPED = 2'd1,
        STAT_POPPED  = 2'd2,
        STAT_REFUSED = 2'd3
    } t_status;

    // Item kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_push;    // Write the sample and report a push.
        logic do_drop;    // Report a dropped push.
        logic do_refuse;  // Report a refused pop.
        logic pop_start;  // Read the oldest sample and load the pop count.
        logic pop_emit;   // Deliver the read sample and fetch the next one unless it is the final one.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // No free entry is left.
        logic pop_ok;     // The requested count is legal and available.
        logic rem_last;   // The sample being delivered is the final one.
        logic out_free;   // The output register can take a result this cycle.
    } t_dp_stat;

endpackage

>>> design/srfifo_if.sv
// Input channel: one push or pop item per transfer.
interface srfifo_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [srfifo_pkg::SAMPLE_W-1:0] sample_in;
    logic [srfifo_pkg::COUNT_W-1:0]  pop_count;

    modport source (output valid, output kind, output sample_in, output pop_count,
                    input ready);
    modport sink   (input valid, input kind, input sample_in, input pop_count,
                    output ready);
endinterface

// Output channel: one result per transfer.
interface srfifo_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [srfifo_pkg::SAMPLE_W-1:0] sample_out;
    logic                            last;
    logic [srfifo_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output sample_out, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input sample_out, input last,
                    input occupancy, output ready);
endinterface

>>> design/srfifo_ctrl.sv
module srfifo_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_kind,
    input  srfifo_pkg::t_dp_stat i_stat,
    output logic                 o_in_ready,
    output srfifo_pkg::t_cmd     o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    t_state           r_state;
    t_state           n_state;
    srfifo_pkg::t_cmd n_cmd;
    logic             n_in_ready;

    // Decode the next state and the datapath commands.
    always_comb begin
        n_state    = r_state;
        n_cmd      = '0;
        n_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (i_in_kind == srfifo_pkg::KIND_PUSH) begin
                        n_cmd.do_push = !i_stat.full;
                        n_cmd.do_drop = i_stat.full;
                    end else if (i_stat.pop_ok) begin
                        n_cmd.pop_start = 1'b1;
                        n_state         = ST_POP;
                    end else begin
                        n_cmd.do_refuse = 1'b1;
                    end
                end
            end
            ST_POP: begin
                if (i_stat.out_free) begin
                    n_cmd.pop_emit = 1'b1;
                    if (i_stat.rem_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = n_in_ready;
    assign o_cmd      = n_cmd;

endmodule

>>> design/srfifo_dp.sv
module srfifo_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srfifo_pkg::t_cmd                    i_cmd,
    output srfifo_pkg::t_dp_stat                o_stat,
    input  logic [srfifo_pkg::SAMPLE_W-1:0]     i_sample_in,
    input  logic [srfifo_pkg::COUNT_W-1:0]      i_pop_count,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [1:0]                          o_status,
    output logic [srfifo_pkg::SAMPLE_W-1:0]     o_sample_out,
    output logic                                o_last,
    output logic [srfifo_pkg::OCC_W-1:0]        o_occupancy
);

    logic [srfifo_pkg::SAMPLE_W-1:0] r_mem [srfifo_pkg::DEPTH];
    logic [srfifo_pkg::SAMPLE_W-1:0] r_rd_data;
    logic [srfifo_pkg::PTR_W-1:0]    r_wr_ptr;
    logic [srfifo_pkg::PTR_W-1:0]    r_rd_ptr;
    logic [srfifo_pkg::PTR_W-1:0]    r_occ;
    logic [srfifo_pkg::COUNT_W-1:0]  r_remain;

    logic                            r_out_valid;
    logic [1:0]                      r_status;
    logic [srfifo_pkg::SAMPLE_W-1:0] r_sample_out;
    logic                            r_last;
    logic [srfifo_pkg::OCC_W-1:0]    r_occupancy;

    logic                            rd_en;
    logic [srfifo_pkg::PTR_W-1:0]    rd_addr;
    logic                            emit;

    // Status toward the controller.
    always_comb begin
        o_stat.full     = (r_occ == srfifo_pkg::PTR_W'(srfifo_pkg::DEPTH - 1));
        o_stat.pop_ok   = (i_pop_count != '0)
                       && (i_pop_count <= srfifo_pkg::COUNT_W'(srfifo_pkg::MAX_POP))
                       && (r_occ >= srfifo_pkg::PTR_W'(i_pop_count));
        o_stat.rem_last = (r_remain == srfifo_pkg::COUNT_W'(1));
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // The first read of a pop takes the oldest entry; each delivery but the final one fetches the one after it.
    assign rd_en   = i_cmd.pop_start || (i_cmd.pop_emit && !o_stat.rem_last);
    assign rd_addr = i_cmd.pop_start ? r_rd_ptr : r_rd_ptr + 1'b1;
    assign emit    = i_cmd.do_push || i_cmd.do_drop || i_cmd.do_refuse || i_cmd.pop_emit;

    // Sample memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_push) begin
            r_mem[r_wr_ptr] <= i_sample_in;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Pointers, fill level and remaining pop count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
            r_remain <= '0;
        end else begin
            if (i_cmd.do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
                r_occ    <= r_occ + 1'b1;
            end
            if (i_cmd.pop_start) begin
                r_remain <= i_pop_count;
            end
            if (i_cmd.pop_emit) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_occ    <= r_occ - 1'b1;
                r_remain <= r_remain - 1'b1;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_push) begin
            r_status     <= srfifo_pkg::STAT_PUSHED;
            r_sample_out <= '0;
            r_last       <= 1'b1;
            r_occupancy  <= srfifo_pkg::OCC_W'(r_occ + 1'b1);
        end else if (i_cmd.do_drop) begin
            r_status     <= srfifo_pkg::STAT_DROPPED;
            r_sample_out <= '0;
            r_last       <= 1'b1;
            r_occupancy  <= srfifo_pkg::OCC_W'(r_occ);
        end else if (i_cmd.do_refuse) begin
            r_status     <= srfifo_pkg::STAT_REFUSED;
            r_sample_out <= '0;
            r_last       <= 1'b1;
            r_occupancy  <= srfifo_pkg::OCC_W'(r_occ);
        end else if (i_cmd.pop_emit) begin
            r_status     <= srfifo_pkg::STAT_POPPED;
            r_sample_out <= r_rd_data;
            r_last       <= o_stat.rem_last;
            r_occupancy  <= srfifo_pkg::OCC_W'(r_occ - 1'b1);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_sample_out = r_sample_out;
    assign o_last       = r_last;
    assign o_occupancy  = r_occupancy;

endmodule

>>> design/sample_ring_fifo_block_pop.sv
// Ring buffer of 1024 32-bit samples that holds at most 1023 at once. A push item
// writes one sample, or is reported as dropped when the buffer is full; a pop item
// asks for 1 to 64 samples and either gets all of them, oldest first with the final
// one marked, or one refusal result. Every result carries the fill level after it.
// A pop first reads the oldest sample through the memory's registered read port, then
// delivers one sample per cycle while the output side takes them. A result waits in
// a single output register; outside a pop, the next item is taken in the same cycle
// that this register frees up, and no item is taken while a pop is delivering.
module sample_ring_fifo_block_pop (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srfifo_in_if.sink     i_in,
    srfifo_out_if.source  o_out
);

    srfifo_pkg::t_cmd     cmd;
    srfifo_pkg::t_dp_stat stat;
    logic                 in_ready;

    // Sequencing of push and pop items.
    srfifo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Storage, pointers and the output register.
    srfifo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_sample_in  (i_in.sample_in),
        .i_pop_count  (i_in.pop_count),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_status     (o_out.status),
        .o_sample_out (o_out.sample_out),
        .o_last       (o_out.last),
        .o_occupancy  (o_out.occupancy)
    );

    assign i_in.ready = in_ready;

endmodule
